>>> src/tpq_pkg.sv
// Shared types, codes and the length table of the telemetry priority queue.
package tpq_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_RETRIEVE = 2'd1,
        OP_PEEK     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADPRIO = 3'd3,
        ST_NOPOS   = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [1:0]  prio;
        logic [4:0]  length;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   add;
        logic   pop;
        entry_t new_entry;
    } cell_ctl_t;

    function automatic logic [4:0] len_of_type(input logic [1:0] tcode);
        logic [4:0] len;
        case (tcode)
            2'd0:    len = 5'd28;
            2'd1:    len = 5'd28;
            2'd2:    len = 5'd3;
            2'd3:    len = 5'd4;
            default: len = 5'd28;
        endcase
        return len;
    endfunction

endpackage

>>> src/tpq_if.sv
// Request and response channel interfaces of the telemetry priority queue.
interface tpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  priority_req;
    logic [31:0] frame_handle;
    logic [7:0]  type_byte;
    logic [3:0]  position;

    modport source (output valid, op, priority_req, frame_handle, type_byte, position,
                    input ready);
    modport sink (input valid, op, priority_req, frame_handle, type_byte, position,
                  output ready);
endinterface

interface tpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [1:0]  out_priority;
    logic [4:0]  out_length;
    logic [4:0]  occupancy;

    modport source (output valid, status, out_handle, out_priority, out_length, occupancy,
                    input ready);
    modport sink (input valid, status, out_handle, out_priority, out_length, occupancy,
                  output ready);
endinterface

>>> src/tpq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module tpq_cell (
    input  logic               clk,
    input  tpq_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  logic               left_ge,
    input  tpq_pkg::entry_t    left_q,
    input  tpq_pkg::entry_t    right_q,
    output tpq_pkg::entry_t    q,
    output logic               ge
);
    import tpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // The held entries are sorted, so ge is high on a prefix of the chain.
    assign ge = valid && (entry_reg.prio >= ctl.new_entry.prio);
    assign q  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.add && !ge)
        begin
            if (left_ge)
            begin
                entry_next = ctl.new_entry;
            end
            else
            begin
                entry_next = left_q;
            end
        end
        else if (ctl.pop)
        begin
            entry_next = right_q;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> src/telemetry_priority_queue.sv
// Top level: control, result register and the chain of entry cells.
// The result of an accepted item is written into the output register at the following clock edge.
// Throughput: one item per cycle while the response side keeps up; all cells shift, insert or hold on the same edge.
// The next item is taken while a result waits only if that result is taken the same cycle.
// Reset clears the entry count and the result valid; entry payloads are not reset.
module telemetry_priority_queue #(
    parameter int CAPACITY = tpq_pkg::CAPACITY_DEF
) (
    input logic clk,
    input logic rst_n,
    tpq_req_if.sink   req,
    tpq_rsp_if.source rsp
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = CNT_W + 4;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    status_t          status_reg;
    status_t          status_next;
    entry_t           res_reg;
    entry_t           res_next;
    logic [4:0]       occ_reg;
    logic [4:0]       occ_next;

    cell_ctl_t        ctl;
    entry_t           cell_q [CAPACITY];
    logic             cell_ge [CAPACITY];
    logic             cell_valid [CAPACITY];
    entry_t           peek_sel;

    logic             fire;
    op_t              op;
    logic             empty;
    logic             full;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    count_ext;
    logic [CNT_W+4:0] occ_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign op        = op_t'(req.op);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = PW'(req.position);
    assign count_ext = PW'(count_reg);

    assign ctl.new_entry.handle = req.frame_handle;
    assign ctl.new_entry.prio   = req.priority_req[1:0];
    assign ctl.new_entry.length = len_of_type(req.type_byte[1:0]);
    assign ctl.add = fire && (op == OP_ADD) && (req.priority_req[2] == 1'b0) && !full;
    assign ctl.pop = fire && (op == OP_RETRIEVE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_valid[gi] = (count_ext > PW'(gi));
            if (gi == 0)
            begin : g_head
                tpq_cell u_cell (
                    .clk     (clk),
                    .ctl     (ctl),
                    .valid   (cell_valid[gi]),
                    .left_ge (1'b1),
                    .left_q  (ctl.new_entry),
                    .right_q (cell_q[(gi + 1) % CAPACITY]),
                    .q       (cell_q[gi]),
                    .ge      (cell_ge[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                tpq_cell u_cell (
                    .clk     (clk),
                    .ctl     (ctl),
                    .valid   (cell_valid[gi]),
                    .left_ge (cell_ge[gi - 1]),
                    .left_q  (cell_q[gi - 1]),
                    .right_q (cell_q[gi]),
                    .q       (cell_q[gi]),
                    .ge      (cell_ge[gi])
                );
            end
            else
            begin : g_mid
                tpq_cell u_cell (
                    .clk     (clk),
                    .ctl     (ctl),
                    .valid   (cell_valid[gi]),
                    .left_ge (cell_ge[gi - 1]),
                    .left_q  (cell_q[gi - 1]),
                    .right_q (cell_q[gi + 1]),
                    .q       (cell_q[gi]),
                    .ge      (cell_ge[gi])
                );
            end
        end
    endgenerate

    // Each cell drives its entry onto the peek bus when its index matches.
    always_comb
    begin
        peek_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos_ext == PW'(i))
            begin
                peek_sel = peek_sel | cell_q[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.add)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        occ_ext  = {5'b0, count_next};
        occ_next = occ_ext[4:0];

        status_next = ST_OK;
        res_next    = '0;
        case (op)
            OP_ADD:
            begin
                if (req.priority_req[2])
                begin
                    status_next = ST_BADPRIO;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    res_next.length = ctl.new_entry.length;
                end
            end
            OP_RETRIEVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    res_next = cell_q[0];
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_ext >= count_ext)
                begin
                    status_next = ST_NOPOS;
                end
                else
                begin
                    res_next = peek_sel;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            res_reg    <= res_next;
            occ_reg    <= occ_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_handle   = res_reg.handle;
    assign rsp.out_priority = res_reg.prio;
    assign rsp.out_length   = res_reg.length;
    assign rsp.occupancy    = occ_reg;

endmodule
